/* rtl/core/tthd_pkg.sv */
package tthd_pkg;

  // Angle and iteration constants.
  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 8;
  localparam int TableFrac     = 24;
  localparam int SqrtIters     = 24;

  // Datapath widths.
  localparam int XyW     = 27;
  localparam int ZW      = 34;
  localparam int StepW   = 5;
  localparam int RndShift = TableFrac - AngleFracBits;
  localparam int RW      = ZW - RndShift;
  localparam int RootW   = 24;
  localparam int RemW    = 26;
  localparam int RadInW  = 48;

  localparam logic [ZW-1:0] HalfTurn = ZW'(64'd180 << TableFrac);
  localparam logic [RW-1:0] RollLimit  = RW'(180 << AngleFracBits);
  localparam logic [RW-1:0] PitchLimit = RW'(90 << AngleFracBits);

  typedef enum logic [1:0] {
    REQ_BACK_SAMPLE = 2'd0,
    REQ_NECK_SAMPLE = 2'd1,
    REQ_COMMAND     = 2'd2,
    REQ_TICK        = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CMD_NECK_UP    = 2'd0,
    CMD_NECK_DOWN  = 2'd1,
    CMD_BACK_RIGHT = 2'd2,
    CMD_BACK_LEFT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ROLL_THRESHOLD  = 2'd0,
    CFG_PITCH_THRESHOLD = 2'd1,
    CFG_MOTOR_DUTY      = 2'd2,
    CFG_HOLD_TICKS      = 2'd3
  } cfg_e;

  // Forward means right for the back pair and up for the neck pair.
  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_CINIT,
    ST_CSTEP,
    ST_CEND,
    ST_DONE
  } state_e;

  // atan(2^-i) in 2^-24 degree units.
  function automatic logic [29:0] atan_lut(input logic [StepW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/tilt_threshold_haptic_driver.sv */
// Channel  | Handshake                  | Word contents
// ---------+----------------------------+----------------------------------------------
// in       | in_valid_i / in_ready_o    | req_type, accel_x/y/z, command_code
// out      | out_valid_o / out_ready_i  | four motor duties, roll, pitch, angle_valid
// cfg      | cfg_we_i (no wait)         | cfg_index_i selects, cfg_data_i written
//
// A sample word goes through the squaring of y and z on the shared 16x16
// multiplier, the bit-pair square root and two CORDIC passes (load, 16
// rotations, round) on one shift-add unit. A command or tick word goes
// from accept straight to the result state. in_ready_o is high
// only in the idle state; a finished result waits in the output register while
// the next word is accepted. rst_ni clears the drive state, hold counters and
// configuration to their defaults at once; no clearing pass is needed.
module tilt_threshold_haptic_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [1:0]  command_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  back_left_duty_o,
  output logic [7:0]  back_right_duty_o,
  output logic [7:0]  neck_up_duty_o,
  output logic [7:0]  neck_down_duty_o,
  output logic signed [16:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic        angle_valid_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int XyW    = tthd_pkg::XyW;
  localparam int ZW     = tthd_pkg::ZW;
  localparam int RW     = tthd_pkg::RW;
  localparam int StepW  = tthd_pkg::StepW;
  localparam int RootW  = tthd_pkg::RootW;
  localparam int RemW   = tthd_pkg::RemW;
  localparam int RadInW = tthd_pkg::RadInW;

  // Configuration registers.
  logic [15:0] roll_thr_q;
  logic [14:0] pitch_thr_q;
  logic [7:0]  duty_q;
  logic [15:0] hold_ticks_q;

  // Control state.
  tthd_pkg::state_e state_q, state_d;
  tthd_pkg::drive_e back_drive_q, neck_drive_q, back_drive_d, neck_drive_d;
  logic [15:0] back_hold_q, neck_hold_q, back_hold_d, neck_hold_d;
  logic [StepW-1:0] cnt_q;
  logic             pass_q;
  logic             out_valid_q;

  // Latched input word.
  tthd_pkg::req_e req_q;
  tthd_pkg::cmd_e code_q;
  logic signed [15:0] ax_q, ay_q, az_q;

  // Square root datapath.
  logic [31:0]       sq_q;
  logic [RadInW-1:0] rad_in_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;

  // CORDIC datapath.
  logic signed [XyW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0]  cz_q;
  logic                  zero_q;
  logic signed [16:0]    roll_q;
  logic signed [15:0]    pitch_q;

  // Output register.
  logic [7:0]         bl_q, br_q, nu_q, nd_q;
  logic signed [16:0] roll_out_q;
  logic signed [15:0] pitch_out_q;
  logic               ang_valid_q;

  logic out_free;
  logic accept;
  logic is_sample;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == tthd_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (req_q == tthd_pkg::REQ_BACK_SAMPLE) ||
                      (req_q == tthd_pkg::REQ_NECK_SAMPLE);

  // Shared squaring multiplier: y first, then z.
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_p;
  assign mul_a = (state_q == tthd_pkg::ST_SQ_Y) ? ay_q : az_q;
  assign mul_p = mul_a * mul_a;

  // One result bit of the square root per cycle.
  logic [RemW+1:0] rem_sh, trial;
  logic            take;
  assign rem_sh = {rem_q, rad_in_q[RadInW-1 -: 2]};
  assign trial  = (RemW+2)'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);

  // Operand selection for the CORDIC load.
  logic signed [XyW-1:0] num, den;
  always_comb begin
    if (!pass_q) begin
      num = XyW'({{(XyW-24){ay_q[15]}}, ay_q, 8'd0});
      den = XyW'({{(XyW-24){az_q[15]}}, az_q, 8'd0});
    end else begin
      num = XyW'({{(XyW-24){ax_q[15]}}, ax_q, 8'd0});
      den = XyW'({{(XyW-RootW){1'b0}}, root_q});
    end
  end

  // One vectoring rotation per cycle.
  logic signed [XyW-1:0] xs, ys;
  logic signed [ZW-1:0]  at;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = ZW'({4'd0, tthd_pkg::atan_lut(cnt_q)});

  // Rounding half away from zero and clamping at the end of a pass.
  logic [ZW-1:0]        zmag, zrnd;
  logic [RW-1:0]        rfull, rlim, rclamp;
  logic signed [RW:0]   rsigned;
  always_comb begin
    zmag    = cz_q[ZW-1] ? ZW'(-cz_q) : ZW'(cz_q);
    zrnd    = zmag + (ZW'(1) << (tthd_pkg::RndShift - 1));
    rfull   = zrnd[ZW-1 -: RW];
    rlim    = pass_q ? tthd_pkg::PitchLimit : tthd_pkg::RollLimit;
    rclamp  = (rfull > rlim) ? rlim : rfull;
    if (zero_q) begin
      rsigned = '0;
    end else if (cz_q[ZW-1]) begin
      rsigned = -$signed({1'b0, rclamp});
    end else begin
      rsigned = $signed({1'b0, rclamp});
    end
  end

  // Drive and hold update applied when the result is produced.
  logic [15:0]        hold_len;
  logic signed [17:0] roll_x, roll_thr_x;
  logic signed [16:0] pitch_x, pitch_thr_x;
  always_comb begin
    hold_len     = (hold_ticks_q == 16'd0) ? 16'd1 : hold_ticks_q;
    roll_x       = 18'(roll_q);
    roll_thr_x   = $signed({2'b00, roll_thr_q});
    pitch_x      = 17'(pitch_q);
    pitch_thr_x  = $signed({2'b00, pitch_thr_q});
    back_drive_d = back_drive_q;
    neck_drive_d = neck_drive_q;
    back_hold_d  = back_hold_q;
    neck_hold_d  = neck_hold_q;
    case (req_q)
      tthd_pkg::REQ_BACK_SAMPLE: begin
        if (back_hold_q == 16'd0) begin
          if (roll_x > roll_thr_x) begin
            back_drive_d = tthd_pkg::DRV_FWD;
          end else if (roll_x < -roll_thr_x) begin
            back_drive_d = tthd_pkg::DRV_REV;
          end else begin
            back_drive_d = tthd_pkg::DRV_OFF;
          end
        end
      end
      tthd_pkg::REQ_NECK_SAMPLE: begin
        if (neck_hold_q == 16'd0) begin
          if (pitch_x > pitch_thr_x) begin
            neck_drive_d = tthd_pkg::DRV_FWD;
          end else if (pitch_x < -pitch_thr_x) begin
            neck_drive_d = tthd_pkg::DRV_REV;
          end else begin
            neck_drive_d = tthd_pkg::DRV_OFF;
          end
        end
      end
      tthd_pkg::REQ_COMMAND: begin
        case (code_q)
          tthd_pkg::CMD_NECK_UP: begin
            neck_drive_d = tthd_pkg::DRV_FWD;
            neck_hold_d  = hold_len;
          end
          tthd_pkg::CMD_NECK_DOWN: begin
            neck_drive_d = tthd_pkg::DRV_REV;
            neck_hold_d  = hold_len;
          end
          tthd_pkg::CMD_BACK_RIGHT: begin
            back_drive_d = tthd_pkg::DRV_FWD;
            back_hold_d  = hold_len;
          end
          default: begin
            back_drive_d = tthd_pkg::DRV_REV;
            back_hold_d  = hold_len;
          end
        endcase
      end
      default: begin
        if (back_hold_q != 16'd0) begin
          back_hold_d = back_hold_q - 16'd1;
          if (back_hold_q == 16'd1) begin
            back_drive_d = tthd_pkg::DRV_OFF;
          end
        end
        if (neck_hold_q != 16'd0) begin
          neck_hold_d = neck_hold_q - 16'd1;
          if (neck_hold_q == 16'd1) begin
            neck_drive_d = tthd_pkg::DRV_OFF;
          end
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tthd_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i == tthd_pkg::REQ_BACK_SAMPLE ||
              req_type_i == tthd_pkg::REQ_NECK_SAMPLE) begin
            state_d = tthd_pkg::ST_SQ_Y;
          end else begin
            state_d = tthd_pkg::ST_DONE;
          end
        end
      end
      tthd_pkg::ST_SQ_Y: state_d = tthd_pkg::ST_SQ_Z;
      tthd_pkg::ST_SQ_Z: state_d = tthd_pkg::ST_SQRT;
      tthd_pkg::ST_SQRT: begin
        if (cnt_q == StepW'(tthd_pkg::SqrtIters - 1)) begin
          state_d = tthd_pkg::ST_CINIT;
        end
      end
      tthd_pkg::ST_CINIT: state_d = tthd_pkg::ST_CSTEP;
      tthd_pkg::ST_CSTEP: begin
        if (cnt_q == StepW'(tthd_pkg::CordicSteps - 1)) begin
          state_d = tthd_pkg::ST_CEND;
        end
      end
      tthd_pkg::ST_CEND: begin
        state_d = pass_q ? tthd_pkg::ST_DONE : tthd_pkg::ST_CINIT;
      end
      tthd_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tthd_pkg::ST_IDLE;
        end
      end
      default: state_d = tthd_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tthd_pkg::ST_IDLE;
      back_drive_q <= tthd_pkg::DRV_OFF;
      neck_drive_q <= tthd_pkg::DRV_OFF;
      back_hold_q  <= '0;
      neck_hold_q  <= '0;
      cnt_q        <= '0;
      pass_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      roll_thr_q   <= 16'd3840;
      pitch_thr_q  <= 15'd2560;
      duty_q       <= 8'd150;
      hold_ticks_q <= 16'd1000;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tthd_pkg::CFG_ROLL_THRESHOLD:  roll_thr_q   <= cfg_data_i;
          tthd_pkg::CFG_PITCH_THRESHOLD: pitch_thr_q  <= cfg_data_i[14:0];
          tthd_pkg::CFG_MOTOR_DUTY:      duty_q       <= cfg_data_i[7:0];
          tthd_pkg::CFG_HOLD_TICKS:      hold_ticks_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q) inside
        tthd_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          pass_q <= 1'b0;
        end
        tthd_pkg::ST_SQRT, tthd_pkg::ST_CSTEP: begin
          cnt_q <= (state_d == state_q) ? cnt_q + StepW'(1) : '0;
        end
        tthd_pkg::ST_CEND: begin
          pass_q <= 1'b1;
          cnt_q  <= '0;
        end
        default: ;
      endcase

      // A new result replaces the one leaving in the same cycle.
      if (state_q == tthd_pkg::ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        back_drive_q <= back_drive_d;
        neck_drive_q <= neck_drive_d;
        back_hold_q  <= back_hold_d;
        neck_hold_q  <= neck_hold_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= tthd_pkg::req_e'(req_type_i);
      code_q <= tthd_pkg::cmd_e'(command_code_i);
      ax_q   <= accel_x_i;
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
    end

    case (state_q)
      tthd_pkg::ST_SQ_Y: sq_q <= mul_p[31:0];
      tthd_pkg::ST_SQ_Z: begin
        sq_q     <= sq_q + mul_p[31:0];
        rad_in_q <= {sq_q + mul_p[31:0], 16'd0};
        rem_q    <= '0;
        root_q   <= '0;
      end
      tthd_pkg::ST_SQRT: begin
        rad_in_q <= rad_in_q << 2;
        if (take) begin
          rem_q  <= RemW'(rem_sh - trial);
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= RemW'(rem_sh);
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      tthd_pkg::ST_CINIT: begin
        zero_q <= (num == '0) && (den == '0);
        if (den[XyW-1]) begin
          cx_q <= -den;
          cy_q <= -num;
          cz_q <= num[XyW-1] ? -$signed(tthd_pkg::HalfTurn)
                             : $signed(tthd_pkg::HalfTurn);
        end else begin
          cx_q <= den;
          cy_q <= num;
          cz_q <= '0;
        end
      end
      tthd_pkg::ST_CSTEP: begin
        if (!cy_q[XyW-1]) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end
      end
      tthd_pkg::ST_CEND: begin
        if (pass_q) begin
          pitch_q <= rsigned[15:0];
        end else begin
          roll_q <= rsigned[16:0];
        end
      end
      default: ;
    endcase

    if (state_q == tthd_pkg::ST_DONE && out_free) begin
      bl_q        <= (back_drive_d == tthd_pkg::DRV_REV) ? duty_q : 8'd0;
      br_q        <= (back_drive_d == tthd_pkg::DRV_FWD) ? duty_q : 8'd0;
      nu_q        <= (neck_drive_d == tthd_pkg::DRV_FWD) ? duty_q : 8'd0;
      nd_q        <= (neck_drive_d == tthd_pkg::DRV_REV) ? duty_q : 8'd0;
      roll_out_q  <= is_sample ? roll_q : '0;
      pitch_out_q <= is_sample ? pitch_q : '0;
      ang_valid_q <= is_sample;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign back_left_duty_o  = bl_q;
  assign back_right_duty_o = br_q;
  assign neck_up_duty_o    = nu_q;
  assign neck_down_duty_o  = nd_q;
  assign roll_angle_o      = roll_out_q;
  assign pitch_angle_o     = pitch_out_q;
  assign angle_valid_o     = ang_valid_q;

endmodule
